// ===== hw/rtl/dbf_pkg.sv =====
// shared types and constants for the 3x3 depth box filter
// no dependencies; compiled before every other file of the block

package dbf_pkg;

    typedef logic [15:0] sample_t;
    typedef logic [8:0]  coord_t;
    typedef logic [9:0]  cfg_data_t;

    // kind of input beat
    typedef enum logic
    {
        ACT_PIXEL = 1'b0,
        ACT_FLUSH = 1'b1
    } action_t;

    // configuration register indexes
    typedef enum logic
    {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    // position and end-of-frame mark that travel with a result
    typedef struct packed
    {
        coord_t col;
        coord_t row;
        logic   done;
    } pos_tag_t;

    typedef struct packed
    {
        sample_t  value;
        pos_tag_t tag;
    } result_t;

    localparam int MIN_DIM          = 2;
    localparam int RST_FRAME_WIDTH  = 320;
    localparam int RST_FRAME_HEIGHT = 240;

    // column sum of three samples, sum of two columns, sum of nine samples
    localparam int COLSUM_W = 18;
    localparam int PAIR_W   = 19;
    localparam int SUM_W    = 20;

    // floor(x / 9) = (x * 466034) >> 22, exact for x < 2**21
    localparam int               MULT_W     = 19;
    localparam int               PROD_W     = SUM_W + MULT_W;
    localparam logic [MULT_W-1:0] DIV9_MULT = 19'd466034;
    localparam int               DIV9_SHIFT = 22;

    // result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int OCC_W      = 4;

endpackage

// ===== hw/rtl/dbf_stream_if.sv =====
// valid/ready stream interfaces for the depth box filter
// depends on dbf_pkg for the payload types

interface dbf_in_if;
    logic             valid;
    logic             ready;
    logic             action;
    dbf_pkg::sample_t pixel_value;

    modport source (output valid, output action, output pixel_value, input ready);
    modport sink   (input valid, input action, input pixel_value, output ready);
endinterface

interface dbf_out_if;
    logic             valid;
    logic             ready;
    dbf_pkg::sample_t smoothed_value;
    dbf_pkg::coord_t  out_column;
    dbf_pkg::coord_t  out_row;
    logic             frame_done;

    modport source (output valid, output smoothed_value, output out_column,
                    output out_row, output frame_done, input ready);
    modport sink   (input valid, input smoothed_value, input out_column,
                    input out_row, input frame_done, output ready);
endinterface

// ===== hw/rtl/dbf_line_store.sv =====
// two line stores holding the previous two rows of samples
// depends on dbf_pkg; registered read, one write per cycle

module dbf_line_store #(
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  dbf_pkg::sample_t         wr_data,
    output dbf_pkg::sample_t         up_data,
    output dbf_pkg::sample_t         mid_data
);

    dbf_pkg::sample_t upper_mem  [DEPTH];
    dbf_pkg::sample_t middle_mem [DEPTH];
    dbf_pkg::sample_t up_q_reg;
    dbf_pkg::sample_t mid_q_reg;

    // the row moves up: upper takes what middle held, from the registered middle read
    always_ff @(posedge clk)
    begin
        up_q_reg  <= upper_mem[rd_addr];
        mid_q_reg <= middle_mem[rd_addr];
        if (wr_en)
        begin
            upper_mem[wr_addr]  <= mid_q_reg;
            middle_mem[wr_addr] <= wr_data;
        end
    end

    assign up_data  = up_q_reg;
    assign mid_data = mid_q_reg;

endmodule

// ===== hw/rtl/dbf_out_fifo.sv =====
// small result queue between the filter pipeline and the output channel
// depends on dbf_pkg for the result type and depth

module dbf_out_fifo (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  dbf_pkg::result_t           wr_data,
    input  logic                       rd_en,
    output dbf_pkg::result_t           rd_data,
    output logic [dbf_pkg::OCC_W-1:0]  count
);

    dbf_pkg::result_t                entry_reg [dbf_pkg::FIFO_DEPTH];
    logic [dbf_pkg::FIFO_AW-1:0]     wr_ptr_reg;
    logic [dbf_pkg::FIFO_AW-1:0]     rd_ptr_reg;
    logic [dbf_pkg::OCC_W-1:0]       count_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + dbf_pkg::FIFO_AW'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + dbf_pkg::FIFO_AW'(1);
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + dbf_pkg::OCC_W'(1);
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - dbf_pkg::OCC_W'(1);
            end
        end
    end

    assign rd_data = entry_reg[rd_ptr_reg];
    assign count   = count_reg;

endmodule

// ===== hw/rtl/depth_box_filter_3x3_top.sv =====
// top level of the 3x3 box filter for raster depth samples
// depends on dbf_pkg, dbf_stream_if, dbf_line_store and dbf_out_fifo
//
// channel    dir  handshake          payload
// samples    in   valid/ready        action, pixel_value
// smoothed   out  valid/ready        smoothed_value, out_column, out_row, frame_done
// cfg        in   cfg_wr_en only     cfg_index, cfg_wr_data
//
// one beat accepted per cycle while samples.ready is high; a result is registered
// through the line store read, window add and divide by 9 before it enters the queue
// the result queue holds eight entries; samples.ready is low while queued and
// in-flight results fill it, so ready never depends on smoothed.ready directly
// reset gives a 320x240 frame at position zero; the line stores need no clear,
// reads of rows not yet written in this frame are masked to zero
// a register write restarts the frame; the user must write only while idle, the block does not enforce it

module depth_box_filter_3x3_top #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  dbf_pkg::cfg_data_t  cfg_wr_data,
    dbf_in_if.sink              samples,
    dbf_out_if.source           smoothed
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WD_W  = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
    localparam int HT_W  = $clog2(MAX_HEIGHT + 1);
    localparam int RST_W = (dbf_pkg::RST_FRAME_WIDTH > MAX_WIDTH) ?
                           MAX_WIDTH : dbf_pkg::RST_FRAME_WIDTH;
    localparam int RST_H = (dbf_pkg::RST_FRAME_HEIGHT > MAX_HEIGHT) ?
                           MAX_HEIGHT : dbf_pkg::RST_FRAME_HEIGHT;

    // ---------------------------------------------------------------
    // configuration: frame size kept already clamped to its legal range
    // ---------------------------------------------------------------
    logic [WD_W-1:0] width_reg;
    logic [HT_W-1:0] height_reg;
    logic [WD_W-1:0] width_clamp;
    logic [HT_W-1:0] height_clamp;

    always_comb
    begin
        if (32'(cfg_wr_data) < dbf_pkg::MIN_DIM)
        begin
            width_clamp  = WD_W'(dbf_pkg::MIN_DIM);
            height_clamp = HT_W'(dbf_pkg::MIN_DIM);
        end
        else
        begin
            width_clamp  = (32'(cfg_wr_data) > MAX_WIDTH) ?
                           WD_W'(MAX_WIDTH) : WD_W'(cfg_wr_data);
            height_clamp = (32'(cfg_wr_data) > MAX_HEIGHT) ?
                           HT_W'(MAX_HEIGHT) : HT_W'(cfg_wr_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WD_W'(RST_W);
            height_reg <= HT_W'(RST_H);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                dbf_pkg::REG_FRAME_WIDTH:  width_reg  <= width_clamp;
                dbf_pkg::REG_FRAME_HEIGHT: height_reg <= height_clamp;
                default:                   width_reg  <= width_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // input stage: position tracking and take/ignore decision
    // ---------------------------------------------------------------
    logic [COL_W-1:0] in_column_reg;
    logic [ROW_W-1:0] in_row_reg;

    logic              accept;
    logic              draining;
    logic              end_drain;
    logic              take;
    logic              first_col;
    logic              emit;
    logic [WD_W-1:0]   col_inc;
    logic              row_wrap;
    logic [COL_W-1:0]  column_next;
    logic [ROW_W-1:0]  row_next;
    logic [WD_W-1:0]   tgt_col;
    logic [ROW_W-1:0]  tgt_row;
    dbf_pkg::pos_tag_t tag_in;
    dbf_pkg::sample_t  val_in;
    logic              in_ready;

    assign accept    = samples.valid && in_ready;
    // rows past the frame are the flush rows
    assign draining  = in_row_reg >= ROW_W'(height_reg);
    assign end_drain = in_row_reg > ROW_W'(height_reg);
    assign take      = accept &&
                       ((samples.action == dbf_pkg::ACT_FLUSH) == draining);
    assign first_col = in_column_reg == '0;
    assign col_inc   = WD_W'(in_column_reg) + WD_W'(1);
    assign row_wrap  = col_inc >= width_reg;
    assign val_in    = draining ? '0 : samples.pixel_value;

    // column 0 closes the right-edge pixel two rows back, any other column
    // closes the pixel one row up and one column left
    assign emit = first_col ? (in_row_reg >= ROW_W'(2)) : (in_row_reg != '0);

    always_comb
    begin
        if (first_col)
        begin
            tgt_col = width_reg - WD_W'(1);
            tgt_row = in_row_reg - ROW_W'(2);
        end
        else
        begin
            tgt_col = WD_W'(in_column_reg) - WD_W'(1);
            tgt_row = in_row_reg - ROW_W'(1);
        end
        tag_in.col  = dbf_pkg::coord_t'(tgt_col);
        tag_in.row  = dbf_pkg::coord_t'(tgt_row);
        // the last pixel of the frame leaves on the final flush beat
        tag_in.done = first_col && end_drain;
    end

    always_comb
    begin
        if (end_drain)
        begin
            column_next = '0;
            row_next    = '0;
        end
        else if (row_wrap)
        begin
            column_next = '0;
            row_next    = in_row_reg + ROW_W'(1);
        end
        else
        begin
            column_next = col_inc[COL_W-1:0];
            row_next    = in_row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_column_reg <= '0;
            in_row_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            in_column_reg <= '0;
            in_row_reg    <= '0;
        end
        else if (take)
        begin
            in_column_reg <= column_next;
            in_row_reg    <= row_next;
        end
    end

    // ---------------------------------------------------------------
    // stage 1: line store data arrives, window update
    // ---------------------------------------------------------------
    logic              s1_valid_reg;
    logic              s1_emit_reg;
    logic              s1_first_reg;
    logic              s1_has_up_reg;
    logic              s1_has_mid_reg;
    logic              s1_restart_reg;
    logic [COL_W-1:0]  s1_idx_reg;
    dbf_pkg::sample_t  s1_val_reg;
    dbf_pkg::pos_tag_t s1_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= take;
            s1_emit_reg  <= take && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_first_reg   <= first_col;
            s1_has_up_reg  <= in_row_reg >= ROW_W'(2);
            s1_has_mid_reg <= in_row_reg != '0;
            s1_restart_reg <= end_drain;
            s1_idx_reg     <= in_column_reg;
            s1_val_reg     <= val_in;
            s1_tag_reg     <= tag_in;
        end
    end

    dbf_pkg::sample_t up_raw;
    dbf_pkg::sample_t mid_raw;

    // read address is the current column, so data lines up with stage 1
    dbf_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk      (clk),
        .rd_addr  (in_column_reg),
        .wr_en    (s1_valid_reg),
        .wr_addr  (s1_idx_reg),
        .wr_data  (s1_val_reg),
        .up_data  (up_raw),
        .mid_data (mid_raw)
    );

    // window kept as the newest column sum and the sum of the two newest
    logic [dbf_pkg::COLSUM_W-1:0] colc_reg;
    logic [dbf_pkg::PAIR_W-1:0]   pair_reg;
    logic [dbf_pkg::COLSUM_W-1:0] new_col;
    logic [dbf_pkg::SUM_W-1:0]    win_sum;
    dbf_pkg::sample_t             up_val;
    dbf_pkg::sample_t             mid_val;

    assign up_val  = s1_has_up_reg  ? up_raw  : '0;
    assign mid_val = s1_has_mid_reg ? mid_raw : '0;
    assign new_col = dbf_pkg::COLSUM_W'(up_val) + dbf_pkg::COLSUM_W'(mid_val) +
                     dbf_pkg::COLSUM_W'(s1_val_reg);
    // right edge: only the two columns already in the window count
    assign win_sum = s1_first_reg ? dbf_pkg::SUM_W'(pair_reg) :
                     dbf_pkg::SUM_W'(pair_reg) + dbf_pkg::SUM_W'(new_col);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colc_reg <= '0;
            pair_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            colc_reg <= '0;
            pair_reg <= '0;
        end
        else if (s1_valid_reg)
        begin
            if (s1_restart_reg)
            begin
                colc_reg <= '0;
                pair_reg <= '0;
            end
            else if (s1_first_reg)
            begin
                colc_reg <= new_col;
                pair_reg <= dbf_pkg::PAIR_W'(new_col);
            end
            else
            begin
                colc_reg <= new_col;
                pair_reg <= dbf_pkg::PAIR_W'(colc_reg) + dbf_pkg::PAIR_W'(new_col);
            end
        end
    end

    // ---------------------------------------------------------------
    // stage 2: divide by 9 through a reciprocal multiply
    // ---------------------------------------------------------------
    logic                          s2_valid_reg;
    logic [dbf_pkg::SUM_W-1:0]     s2_sum_reg;
    dbf_pkg::pos_tag_t             s2_tag_reg;
    logic [dbf_pkg::PROD_W-1:0]    prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_emit_reg)
        begin
            s2_sum_reg <= win_sum;
            s2_tag_reg <= s1_tag_reg;
        end
    end

    assign prod = dbf_pkg::PROD_W'(s2_sum_reg) * dbf_pkg::PROD_W'(dbf_pkg::DIV9_MULT);

    // ---------------------------------------------------------------
    // stage 3: finished result, written into the queue
    // ---------------------------------------------------------------
    logic             s3_valid_reg;
    dbf_pkg::result_t s3_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            s3_res_reg.value <= prod[dbf_pkg::DIV9_SHIFT +: 16];
            s3_res_reg.tag   <= s2_tag_reg;
        end
    end

    dbf_pkg::result_t            fifo_head;
    logic [dbf_pkg::OCC_W-1:0]   fifo_count;
    logic                        out_fire;
    logic [dbf_pkg::OCC_W-1:0]   occupancy;

    assign out_fire = smoothed.valid && smoothed.ready;

    dbf_out_fifo u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (s3_valid_reg),
        .wr_data (s3_res_reg),
        .rd_en   (out_fire),
        .rd_data (fifo_head),
        .count   (fifo_count)
    );

    // every result still in the pipeline has a queue slot reserved
    assign occupancy = fifo_count +
                       dbf_pkg::OCC_W'(s1_valid_reg && s1_emit_reg) +
                       dbf_pkg::OCC_W'(s2_valid_reg) +
                       dbf_pkg::OCC_W'(s3_valid_reg);
    assign in_ready  = occupancy < dbf_pkg::OCC_W'(dbf_pkg::FIFO_DEPTH);

    assign samples.ready           = in_ready;
    assign smoothed.valid          = fifo_count != '0;
    assign smoothed.smoothed_value = fifo_head.value;
    assign smoothed.out_column     = fifo_head.tag.col;
    assign smoothed.out_row        = fifo_head.tag.row;
    assign smoothed.frame_done     = fifo_head.tag.done;

`ifndef SYNTH
    // the queue always has room for a result leaving stage 3
    a_fifo_room: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> (fifo_count < dbf_pkg::OCC_W'(dbf_pkg::FIFO_DEPTH)))
        else $error("result queue overflow");

    // column stays inside the row in use
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        WD_W'(in_column_reg) < width_reg)
        else $error("column beyond frame width");

    // row never passes the single flush row plus the closing beat
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_row_reg <= ROW_W'(height_reg) + ROW_W'(1))
        else $error("row beyond drain end");

    // the closing flush beat returns the stream to the frame start
    a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
        (take && end_drain) |=> (in_row_reg == '0 && in_column_reg == '0))
        else $error("frame did not restart after drain");
`endif

endmodule
